FILE: rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants of the clipped advantage scan
// Field widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int VALUE_W   = 32;   // signed Q16.16
   localparam int RATIO_W   = 31;   // unsigned Q15.16
   localparam int FACTOR_W  = 17;   // unsigned Q1.16, one is 65536
   localparam int ROWLEN_W  = 13;
   localparam int ROWCNT_W  = 16;
   localparam int PROD_W    = 64;
   localparam int RND_W     = 48;   // product rounded back to 16 fraction bits, signed Q31.16
   localparam int ACC_W     = 50;   // exact sum of the advantage terms

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH  = 3'd0,
      CSR_ROW_COUNT   = 3'd1,
      CSR_DISCOUNT    = 3'd2,
      CSR_TRACE_DECAY = 3'd3,
      CSR_REWARD_CLIP = 3'd4,
      CSR_TRACE_CLIP  = 3'd5
   } csr_index_type;

   localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RESET  = 13'd64;
   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET   = 16'd1;
   localparam logic [FACTOR_W-1:0] DISCOUNT_RESET    = 17'd64880;
   localparam logic [FACTOR_W-1:0] TRACE_DECAY_RESET = 17'd62259;
   localparam logic [RATIO_W-1:0]  CLIP_RESET        = 31'd65536;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE        = 17'd65536;

   // Configuration as the datapath sees it: factors and row count already
   // clamped, row length raw (its clamp depends on the top-level parameter).
   typedef struct packed {
      logic [ROWLEN_W-1:0] row_length;
      logic [ROWCNT_W-1:0] row_count;
      logic [FACTOR_W-1:0] discount;
      logic [FACTOR_W-1:0] trace_decay;
      logic [RATIO_W-1:0]  reward_clip;
      logic [RATIO_W-1:0]  trace_clip;
   } cas_cfg_type;

endpackage

FILE: rtl/cas_if.sv
// ----------------------------------------------------------------------------
// cas_req_if / cas_rsp_if: valid/ready channels of the advantage scan
// Step items in, advantage items out; the first step of a row gives no result.
// ----------------------------------------------------------------------------
interface cas_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] step_value;
   logic signed [31:0] step_reward;
   logic               step_done;
   logic [30:0]        importance_ratio;

   modport source (output valid, step_value, step_reward, step_done,
                   importance_ratio, input ready);
   modport sink   (input valid, step_value, step_reward, step_done,
                   importance_ratio, output ready);
endinterface

interface cas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] advantage;
   logic               row_end;
   logic               batch_end;

   modport source (output valid, advantage, row_end, batch_end, input ready);
   modport sink   (input valid, advantage, row_end, batch_end, output ready);
endinterface

FILE: rtl/cas_csr.sv
// ----------------------------------------------------------------------------
// cas_csr: configuration registers
// Write-only register file; clamps the factors and the row count.
// ----------------------------------------------------------------------------
module cas_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [cas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output cas_pkg::cas_cfg_type               cfg
);
   import cas_pkg::*;

   logic [ROWLEN_W-1:0] row_length_ff;
   logic [ROWCNT_W-1:0] row_count_ff;
   logic [FACTOR_W-1:0] discount_ff;
   logic [FACTOR_W-1:0] trace_decay_ff;
   logic [RATIO_W-1:0]  reward_clip_ff;
   logic [RATIO_W-1:0]  trace_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= ROW_LENGTH_RESET;
         row_count_ff   <= ROW_COUNT_RESET;
         discount_ff    <= DISCOUNT_RESET;
         trace_decay_ff <= TRACE_DECAY_RESET;
         reward_clip_ff <= CLIP_RESET;
         trace_clip_ff  <= CLIP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_LENGTH:  row_length_ff  <= csr_write_data[ROWLEN_W-1:0];
            CSR_ROW_COUNT:   row_count_ff   <= csr_write_data[ROWCNT_W-1:0];
            CSR_DISCOUNT:    discount_ff    <= csr_write_data[FACTOR_W-1:0];
            CSR_TRACE_DECAY: trace_decay_ff <= csr_write_data[FACTOR_W-1:0];
            CSR_REWARD_CLIP: reward_clip_ff <= csr_write_data[RATIO_W-1:0];
            CSR_TRACE_CLIP:  trace_clip_ff  <= csr_write_data[RATIO_W-1:0];
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   always_comb begin
      cfg.row_length  = row_length_ff;
      cfg.row_count   = (row_count_ff == '0) ? ROWCNT_W'(1) : row_count_ff;
      cfg.discount    = (discount_ff > FACTOR_ONE) ? FACTOR_ONE : discount_ff;
      cfg.trace_decay = (trace_decay_ff > FACTOR_ONE) ? FACTOR_ONE : trace_decay_ff;
      cfg.reward_clip = reward_clip_ff;
      cfg.trace_clip  = trace_clip_ff;
   end

endmodule

FILE: rtl/cas_mul_unit.sv
// ----------------------------------------------------------------------------
// cas_mul_unit: shared multiplier with registered product
// Unsigned 31-bit times signed 32-bit; gives only the product rounded to
// signed Q31.16 (add half, floor shift by 16).
// ----------------------------------------------------------------------------
module cas_mul_unit (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [cas_pkg::RATIO_W-1:0]         op_a,
   input  logic signed [cas_pkg::VALUE_W-1:0]  op_b,
   output logic signed [cas_pkg::RND_W-1:0]    rounded
);
   import cas_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = $signed({1'b0, op_a}) * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   // floor((p + 2^15) / 2^16) == (p >>> 16) + p[15]
   assign rounded = $signed(prod_ff[PROD_W-1:16]) + $signed({{(RND_W-1){1'b0}}, prod_ff[15]});

endmodule

FILE: rtl/clipped_advantage_scan_core.sv
// ----------------------------------------------------------------------------
// clipped_advantage_scan_core: importance-clipped discounted advantage scan
// Sequencer and accumulator around one shared multiplier.
// ----------------------------------------------------------------------------
// Steps of a row arrive latest first. The first step of a row is only stored
// (no result); every later step yields one saturated Q16.16 advantage,
// delta + gamma*lambda*min(imp,c)*adv_prev, with the trace and bootstrap
// terms dropped when the later step ended an episode. All five products of a
// live step go through a single 31x32 multiplier one after another, with a
// rounding state in between where a rounded product feeds the next multiply;
// the result is loaded in FINISH after MUL_R to ACC_RA when the later step is
// alive and after MUL_R, MUL_V and MUL_GL when it is done, and the next step
// is taken only back in IDLE; the input is not ready meanwhile. The result
// sits in an output register, so a new step can be taken while it waits; the
// sequencer only holds in FINISH if the previous result is still untaken.
// Registers are to be written only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module clipped_advantage_scan_core #(
   parameter int MAX_ROW_LENGTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   cas_req_if.sink                         req_ch,
   cas_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [cas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import cas_pkg::*;

   localparam int POS_W = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);

   typedef enum logic [3:0] {
      IDLE,     // take a step
      MUL_R,    // rho * later reward
      MUL_V,    // gamma * later value; start sum with reward term - v
      MUL_GL,   // gamma * lambda; add bootstrap term
      RND_GL,   // round gamma*lambda
      MUL_GC,   // gl * c
      RND_GC,   // round gl*c
      MUL_RA,   // gc * running advantage
      ACC_RA,   // add trace term
      FINISH    // saturate, update state, load result
   } state_type;

   cas_cfg_type cfg;

   state_type                  state_ff, state_in;
   logic signed [VALUE_W-1:0]  later_value_ff, later_value_in;
   logic signed [VALUE_W-1:0]  later_reward_ff, later_reward_in;
   logic                       later_done_ff, later_done_in;
   logic signed [VALUE_W-1:0]  cur_value_ff, cur_value_in;
   logic signed [VALUE_W-1:0]  cur_reward_ff, cur_reward_in;
   logic                       cur_done_ff, cur_done_in;
   logic [RATIO_W-1:0]         rho_ff, rho_in;
   logic [RATIO_W-1:0]         clip_c_ff, clip_c_in;
   logic [RATIO_W-1:0]         opnd_ff, opnd_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [VALUE_W-1:0]  run_adv_ff, run_adv_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [ROWCNT_W-1:0]        rows_ff, rows_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  advantage_ff, advantage_in;
   logic                       row_end_ff, row_end_in;
   logic                       batch_end_ff, batch_end_in;

   logic                       mul_enable;
   logic [RATIO_W-1:0]         mul_a;
   logic signed [VALUE_W-1:0]  mul_b;
   logic signed [RND_W-1:0]    mul_rnd;
   logic signed [ACC_W-1:0]    rnd_ext;
   logic signed [VALUE_W-1:0]  sat_value;

   logic [LEN_W-1:0]           len_eff;
   logic                       at_row_end;
   logic                       row_last;
   logic [ROWCNT_W-1:0]        rows_after;
   logic                       alive;
   logic                       out_free;

   cas_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cas_mul_unit u_mul (
      .clock   (clock),
      .enable  (mul_enable),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .rounded (mul_rnd)
   );

   // Effective row length: zero counts as one, clamp to the parameter.
   always_comb begin
      if (cfg.row_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(cfg.row_length) > 32'(MAX_ROW_LENGTH)) begin
         len_eff = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = LEN_W'(cfg.row_length);
      end
   end

   assign at_row_end = (LEN_W'(pos_ff) + LEN_W'(1)) >= len_eff;
   assign row_last   = ({1'b0, rows_ff} + (ROWCNT_W+1)'(1)) >= {1'b0, cfg.row_count};
   assign rows_after = row_last ? '0 : rows_ff + ROWCNT_W'(1);
   assign alive      = !later_done_ff;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign rnd_ext    = ACC_W'(mul_rnd);

   // Saturate the exact sum to 32 bits.
   always_comb begin
      if (acc_ff > ACC_W'(signed'(32'sh7FFF_FFFF))) begin
         sat_value = 32'sh7FFF_FFFF;
      end else if (acc_ff < ACC_W'(signed'(32'sh8000_0000))) begin
         sat_value = 32'sh8000_0000;
      end else begin
         sat_value = acc_ff[VALUE_W-1:0];
      end
   end

   // Multiplier operand selection.
   always_comb begin
      mul_enable = 1'b0;
      mul_a      = rho_ff;
      mul_b      = later_reward_ff;
      unique case (state_ff)
         MUL_R: begin
            mul_enable = 1'b1;
         end
         MUL_V: begin
            mul_enable = 1'b1;
            mul_a      = RATIO_W'(cfg.discount);
            mul_b      = later_value_ff;
         end
         MUL_GL: begin
            mul_enable = 1'b1;
            mul_a      = RATIO_W'(cfg.discount);
            mul_b      = $signed(VALUE_W'(cfg.trace_decay));
         end
         MUL_GC: begin
            mul_enable = 1'b1;
            mul_a      = opnd_ff;
            mul_b      = $signed(VALUE_W'(clip_c_ff));
         end
         MUL_RA: begin
            mul_enable = 1'b1;
            mul_a      = opnd_ff;
            mul_b      = run_adv_ff;
         end
         default: ;
      endcase
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in        = state_ff;
      later_value_in  = later_value_ff;
      later_reward_in = later_reward_ff;
      later_done_in   = later_done_ff;
      cur_value_in    = cur_value_ff;
      cur_reward_in   = cur_reward_ff;
      cur_done_in     = cur_done_ff;
      rho_in          = rho_ff;
      clip_c_in       = clip_c_ff;
      opnd_in         = opnd_ff;
      acc_in          = acc_ff;
      run_adv_in      = run_adv_ff;
      pos_in          = pos_ff;
      rows_in         = rows_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      advantage_in    = advantage_ff;
      row_end_in      = row_end_ff;
      batch_end_in    = batch_end_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_ch.valid) begin
               if (pos_ff == '0) begin
                  // First step of a row: store it, no result.
                  later_value_in  = req_ch.step_value;
                  later_reward_in = req_ch.step_reward;
                  later_done_in   = req_ch.step_done;
                  run_adv_in      = '0;
                  if (len_eff == LEN_W'(1)) begin
                     rows_in = rows_after;
                  end else begin
                     pos_in = POS_W'(1);
                  end
               end else begin
                  cur_value_in  = req_ch.step_value;
                  cur_reward_in = req_ch.step_reward;
                  cur_done_in   = req_ch.step_done;
                  rho_in        = (req_ch.importance_ratio < cfg.reward_clip) ?
                                  req_ch.importance_ratio : cfg.reward_clip;
                  clip_c_in     = (req_ch.importance_ratio < cfg.trace_clip) ?
                                  req_ch.importance_ratio : cfg.trace_clip;
                  state_in      = MUL_R;
               end
            end
         end
         MUL_R: begin
            state_in = MUL_V;
         end
         MUL_V: begin
            acc_in   = rnd_ext - ACC_W'(cur_value_ff);
            state_in = MUL_GL;
         end
         MUL_GL: begin
            if (alive) begin
               acc_in   = acc_ff + rnd_ext;
               state_in = RND_GL;
            end else begin
               state_in = FINISH;
            end
         end
         RND_GL: begin
            opnd_in  = RATIO_W'(mul_rnd);   // gamma*lambda, at most one
            state_in = MUL_GC;
         end
         MUL_GC: begin
            state_in = RND_GC;
         end
         RND_GC: begin
            opnd_in  = RATIO_W'(mul_rnd);   // clipped trace factor, below 2^31
            state_in = MUL_RA;
         end
         MUL_RA: begin
            state_in = ACC_RA;
         end
         ACC_RA: begin
            acc_in   = acc_ff + rnd_ext;
            state_in = FINISH;
         end
         FINISH: begin
            // Hold until the output register is free.
            if (out_free) begin
               run_adv_in      = sat_value;
               later_value_in  = cur_value_ff;
               later_reward_in = cur_reward_ff;
               later_done_in   = cur_done_ff;
               rsp_valid_in    = 1'b1;
               advantage_in    = sat_value;
               row_end_in      = at_row_end;
               batch_end_in    = at_row_end && row_last;
               if (at_row_end) begin
                  pos_in  = '0;
                  rows_in = rows_after;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         later_value_ff  <= '0;
         later_reward_ff <= '0;
         later_done_ff   <= 1'b0;
         run_adv_ff      <= '0;
         pos_ff          <= '0;
         rows_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         later_value_ff  <= later_value_in;
         later_reward_ff <= later_reward_in;
         later_done_ff   <= later_done_in;
         run_adv_ff      <= run_adv_in;
         pos_ff          <= pos_in;
         rows_ff         <= rows_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cur_value_ff  <= cur_value_in;
      cur_reward_ff <= cur_reward_in;
      cur_done_ff   <= cur_done_in;
      rho_ff        <= rho_in;
      clip_c_ff     <= clip_c_in;
      opnd_ff       <= opnd_in;
      acc_ff        <= acc_in;
      advantage_ff  <= advantage_in;
      row_end_ff    <= row_end_in;
      batch_end_ff  <= batch_end_in;
   end

   assign req_ch.ready     = (state_ff == IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.advantage = advantage_ff;
   assign rsp_ch.row_end   = row_end_ff;
   assign rsp_ch.batch_end = batch_end_ff;

endmodule

FILE: verif/advantage_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// advantage_scoreboard_pkg: expected advantages for the scan core bench
// Keeps its own copy of the scan state and registers, works out the advantage
// of every non-first step of a row and checks arriving results against them in order.
// ----------------------------------------------------------------------------
package advantage_scoreboard_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import cas_pkg::*;

   localparam int unsigned ROW_LENGTH_LIMIT = 4096;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] reward;
      logic                      done;
      logic [RATIO_W-1:0]        ratio;
   } scan_step_type;

   typedef struct {
      logic signed [VALUE_W-1:0] advantage;
      logic                      row_end;
      logic                      batch_end;
   } scan_result_type;

   class advantage_scoreboard;
      logic [ROWLEN_W-1:0]       row_length;
      logic [ROWCNT_W-1:0]       row_count;
      logic [FACTOR_W-1:0]       discount;
      logic [FACTOR_W-1:0]       trace_decay;
      logic [RATIO_W-1:0]        reward_clip;
      logic [RATIO_W-1:0]        trace_clip;

      logic signed [VALUE_W-1:0] later_value;
      logic signed [VALUE_W-1:0] later_reward;
      logic                      later_done;
      logic signed [VALUE_W-1:0] running_advantage;
      int unsigned               step_in_row;
      int unsigned               rows_finished;

      scan_result_type           awaited[$];
      int                        mismatches;
      int                        steps_noted;
      int                        results_checked;

      function new();
         row_length        = ROW_LENGTH_RESET;
         row_count         = ROW_COUNT_RESET;
         discount          = DISCOUNT_RESET;
         trace_decay       = TRACE_DECAY_RESET;
         reward_clip       = CLIP_RESET;
         trace_clip        = CLIP_RESET;
         later_value       = '0;
         later_reward      = '0;
         later_done        = 1'b0;
         running_advantage = '0;
         step_in_row       = 0;
         rows_finished     = 0;
         mismatches        = 0;
         steps_noted       = 0;
         results_checked   = 0;
      endfunction

      // Round to nearest, ties up, and drop 16 fraction bits.
      static function longint rescale(longint x);
         return (x + 64'sd32768) >>> 16;
      endfunction

      static function logic signed [VALUE_W-1:0] saturate(longint x);
         if (x > 64'sd2147483647)
            return 32'sh7fffffff;
         if (x < -64'sd2147483648)
            return 32'sh80000000;
         return x[VALUE_W-1:0];
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ROW_LENGTH:  row_length  = data[ROWLEN_W-1:0];
            CSR_ROW_COUNT:   row_count   = data[ROWCNT_W-1:0];
            CSR_DISCOUNT:    discount    = data[FACTOR_W-1:0];
            CSR_TRACE_DECAY: trace_decay = data[FACTOR_W-1:0];
            CSR_REWARD_CLIP: reward_clip = data[RATIO_W-1:0];
            CSR_TRACE_CLIP:  trace_clip  = data[RATIO_W-1:0];
            default: ;
         endcase
      endfunction

      // Close the current row; tell whether it also closed the batch.
      function bit close_row();
         int unsigned rows_needed;
         bit          last_row;
         rows_needed   = (row_count == 0) ? 1 : row_count;
         last_row      = (rows_finished + 1 >= rows_needed);
         step_in_row   = 0;
         rows_finished = last_row ? 0 : rows_finished + 1;
         return last_row;
      endfunction

      function void note_step(scan_step_type s);
         int unsigned     steps;
         int unsigned     gamma;
         int unsigned     lambda;
         int unsigned     rho;
         int unsigned     clip;
         longint          delta;
         longint          gl;
         longint          gc;
         longint          total;
         bit              alive;
         scan_result_type r;

         steps_noted++;
         steps  = (row_length == 0) ? 1 : row_length;
         if (steps > ROW_LENGTH_LIMIT)
            steps = ROW_LENGTH_LIMIT;
         gamma  = (discount > FACTOR_ONE) ? FACTOR_ONE : discount;
         lambda = (trace_decay > FACTOR_ONE) ? FACTOR_ONE : trace_decay;

         // First step of a row is only stored.
         if (step_in_row == 0) begin
            later_value       = s.value;
            later_reward      = s.reward;
            later_done        = s.done;
            running_advantage = '0;
            if (steps == 1)
               void'(close_row());
            else
               step_in_row = 1;
            return;
         end

         alive = !later_done;
         rho   = (s.ratio < reward_clip) ? s.ratio : reward_clip;
         clip  = (s.ratio < trace_clip) ? s.ratio : trace_clip;

         delta = rescale(longint'(rho) * longint'(later_reward)) - longint'(s.value);
         if (alive)
            delta += rescale(longint'(gamma) * longint'(later_value));
         total = delta;
         if (alive) begin
            gl    = rescale(longint'(gamma) * longint'(lambda));
            gc    = rescale(gl * longint'(clip));
            total += rescale(gc * longint'(running_advantage));
         end
         running_advantage = saturate(total);

         later_value  = s.value;
         later_reward = s.reward;
         later_done   = s.done;

         r.advantage = running_advantage;
         r.row_end   = (step_in_row + 1 >= steps);
         r.batch_end = 1'b0;
         if (r.row_end)
            r.batch_end = close_row();
         else
            step_in_row++;
         awaited.push_back(r);
      endfunction

      function void check_result(scan_result_type got);
         scan_result_type want;
         results_checked++;
         if (awaited.size() == 0) begin
            $display("%0t: advantage expected none actual %0d (no step pending)",
                     $time, got.advantage);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.advantage !== want.advantage) begin
            $display("%0t: advantage expected %0d actual %0d",
                     $time, want.advantage, got.advantage);
            mismatches++;
         end
         if (got.row_end !== want.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, got.row_end);
            mismatches++;
         end
         if (got.batch_end !== want.batch_end) begin
            $display("%0t: batch_end expected %0b actual %0b",
                     $time, want.batch_end, got.batch_end);
            mismatches++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

endpackage

FILE: verif/clipped_advantage_scan_core_tb.sv
// ----------------------------------------------------------------------------
// clipped_advantage_scan_core_tb: self-checking bench of the advantage scan
// Directed rows at the field and register extremes, then random phases with
// random register settings, random idling on both channels, one long result
// hold-off and one stretch without idling. Every result is checked in order.
// ----------------------------------------------------------------------------
module clipped_advantage_scan_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cas_pkg::*;
   import advantage_scoreboard_pkg::*;

   localparam int IDLE_PERCENT    = 27;
   localparam int RANDOM_PHASES   = 14;
   localparam int HOLD_OFF_PHASE  = 3;
   localparam int STEADY_PHASE    = 7;
   localparam int HOLD_OFF_CYCLES = 300;
   // Room for an item to pass through the block, with margin on top.
   localparam int SETTLE_CYCLES   = 24;
   // The longest quiet stretch of a correct run comes from the result hold-off.
   localparam int WATCHDOG_CYCLES = 2000;
   // Index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   cas_req_if req_ch();
   cas_rsp_if rsp_ch();

   advantage_scoreboard board;
   scan_step_type       step_queue[$];   // steps waiting for their transfer
   int                  idle_pct;
   bit                  hold_off_request;
   int                  hold_off_left;
   int                  quiet_cycles;
   int                  settings_used;

   clipped_advantage_scan_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Step sender: note each transfer in the scoreboard, then offer the next
   // queued step unless this cycle idles. Hold the offer until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            board.note_step(step_queue.pop_front());
         if (req_ch.valid && !req_ch.ready) begin
            // hold the current step
         end else if (step_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_ch.valid            <= 1'b1;
            req_ch.step_value       <= step_queue[0].value;
            req_ch.step_reward      <= step_queue[0].reward;
            req_ch.step_done        <= step_queue[0].done;
            req_ch.importance_ratio <= step_queue[0].ratio;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: check each transfer; stall at random, or for a long
   // counted stretch when asked, so the block fills up and stalls its input.
   always @(posedge clock) begin : result_sink
      scan_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.advantage = rsp_ch.advantage;
         got.row_end   = rsp_ch.row_end;
         got.batch_end = rsp_ch.batch_end;
         board.check_result(got);
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left    = HOLD_OFF_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, board.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   // Drive one register write; the scoreboard takes it at the same edge,
   // the block at the next one. The enable stays up for back-to-back writes.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      board.write_register(index, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] length, count, gamma, lambda,
                            input logic [CSR_DATA_W-1:0] rclip, tclip);
      write_register(CSR_ROW_LENGTH, length);
      write_register(CSR_ROW_COUNT, count);
      write_register(CSR_DISCOUNT, gamma);
      write_register(CSR_TRACE_DECAY, lambda);
      write_register(CSR_REWARD_CLIP, rclip);
      write_register(CSR_TRACE_CLIP, tclip);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic offer_step(input logic signed [VALUE_W-1:0] value, reward,
                             input logic done, input logic [RATIO_W-1:0] ratio);
      scan_step_type s;
      s.value  = value;
      s.reward = reward;
      s.done   = done;
      s.ratio  = ratio;
      step_queue.push_back(s);
   endtask

   // Wait until every step is taken and every result checked, then give a
   // trailing store-only step time to finish before registers change.
   task automatic settle();
      while (step_queue.size() != 0 || board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly values of a few units so that the recurrence stays in range,
   // the rest full-range to drive saturation.
   function automatic scan_step_type random_step();
      scan_step_type s;
      if ($urandom_range(3) == 0) begin
         s.value  = $urandom();
         s.reward = $urandom();
      end else begin
         s.value  = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
         s.reward = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
      end
      s.done = ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0)
         s.ratio = 31'($urandom());
      else
         s.ratio = 31'($urandom_range(0, 3 * 65536));
      return s;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_factor();
      case ($urandom_range(7))
         0:       return CSR_DATA_W'(FACTOR_ONE);
         1:       return CSR_DATA_W'($urandom_range(65537, 131071));   // clamps to one
         2:       return '0;
         default: return CSR_DATA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_clip();
      case ($urandom_range(5))
         0:       return 31'h7fffffff;
         1:       return '0;
         2:       return 31'($urandom());
         default: return CSR_DATA_W'($urandom_range(0, 4 * 65536));
      endcase
   endfunction

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] row_len;
      logic [CSR_DATA_W-1:0] row_cnt;
      int                    phase_steps;

      board                   = new();
      idle_pct                = IDLE_PERCENT;
      hold_off_request        = 1'b0;
      hold_off_left           = 0;
      quiet_cycles            = 0;
      settings_used           = 0;
      req_ch.valid            = 1'b0;
      req_ch.step_value       = '0;
      req_ch.step_reward      = '0;
      req_ch.step_done        = 1'b0;
      req_ch.importance_ratio = '0;
      rsp_ch.ready            = 1'b0;
      csr_write_enable        = 1'b0;
      csr_index               = '0;
      csr_write_data          = '0;
      reset                   = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: store a first step, then opposite extremes, an
      // episode end that drops the bootstrap and trace terms, and a plain step.
      offer_step(32'sh7fffffff, 32'sh80000000, 1'b0, 31'h7fffffff);
      offer_step(32'sh80000000, 32'sh7fffffff, 1'b1, 31'h0);
      offer_step(32'sh0, 32'sh10000, 1'b0, 31'h7fffffff);
      offer_step(32'sh30000, -32'sh10000, 1'b0, 31'h10000);
      settle();

      // Rows of three, two per batch, discount above one, decay at one, clips wide open.
      // The open row is already past the new length, so its next step ends it.
      configure(3, 2, 131071, FACTOR_ONE, 31'h7fffffff, 31'h7fffffff);
      offer_step(32'sh7fffffff, 32'sh7fffffff, 1'b0, 31'h7fffffff);
      offer_step(32'sh80000000, 32'sh80000000, 1'b0, 31'h7fffffff);
      offer_step(32'sh7fffffff, 32'sh80000000, 1'b0, 31'h7fffffff);
      offer_step(32'sh80000000, 32'sh7fffffff, 1'b0, 31'h7fffffff);
      offer_step(32'sh7fffffff, 32'sh7fffffff, 1'b1, 31'h7fffffff);
      offer_step(32'sh80000000, 32'sh80000000, 1'b0, 31'h0);
      offer_step(-32'sh1, 32'sh1, 1'b0, 31'h1);
      offer_step(32'sh1, -32'sh1, 1'b1, 31'h7fffffff);
      settle();

      // Unknown index, then zero row length and zero row count: the next step ends
      // the open row with a result; each later step closes a row on its own, no result.
      write_register(CSR_UNUSED_INDEX, 31'h7fffffff);
      configure(0, 0, FACTOR_ONE, FACTOR_ONE, 0, 0);
      offer_step(32'sh12345678, -32'sh7654321, 1'b1, 31'h7fffffff);
      offer_step(-32'sh5555, 32'sh5555, 1'b0, 31'h2aaaaaaa);
      offer_step(32'sh0, 32'sh0, 1'b0, 31'h0);
      settle();

      // Row length beyond the limit, zero factors and clips.
      configure(8191, 1, 0, 0, 0, 0);
      offer_step(32'sh7fffffff, 32'sh7fffffff, 1'b0, 31'h7fffffff);
      offer_step(32'sh10000, 32'sh20000, 1'b0, 31'h10000);
      offer_step(-32'sh10000, 32'sh7fffffff, 1'b1, 31'h7fffffff);
      offer_step(32'sh80000000, 32'sh80000000, 1'b0, 31'h7fffffff);
      offer_step(32'sh4000, -32'sh4000, 1'b0, 31'h8000);
      settle();

      // Shrink the row mid-way: the next step ends the open row.
      configure(2, 3, FACTOR_ONE, FACTOR_ONE, CLIP_RESET, CLIP_RESET);
      offer_step(32'sh20000, 32'sh10000, 1'b0, 31'h18000);
      offer_step(32'sh10000, 32'sh10000, 1'b0, 31'h8000);
      offer_step(-32'sh20000, 32'sh30000, 1'b0, 31'h20000);
      offer_step(32'sh0, -32'sh10000, 1'b1, 31'h10000);
      offer_step(32'sh8000, 32'sh8000, 1'b0, 31'h4000);
      settle();

      // Random phases: new settings while idle, then a burst of steps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(19))
            0:       row_len = '0;
            1:       row_len = CSR_DATA_W'(1);
            2:       row_len = CSR_DATA_W'($urandom_range(4097, 8191));
            3:       row_len = CSR_DATA_W'($urandom_range(17, 300));
            default: row_len = CSR_DATA_W'($urandom_range(2, 16));
         endcase
         // The hold-off phase needs results, so give it short rows.
         if (phase == HOLD_OFF_PHASE)
            row_len = CSR_DATA_W'($urandom_range(2, 16));
         case ($urandom_range(9))
            0:       row_cnt = '0;
            1:       row_cnt = CSR_DATA_W'(65535);
            2:       row_cnt = CSR_DATA_W'($urandom_range(1, 65535));
            default: row_cnt = CSR_DATA_W'($urandom_range(1, 6));
         endcase
         configure(row_len, row_cnt, pick_factor(), pick_factor(), pick_clip(), pick_clip());
         idle_pct = (phase == STEADY_PHASE) ? 0 : IDLE_PERCENT;
         if (phase == HOLD_OFF_PHASE)
            hold_off_request = 1'b1;
         phase_steps = $urandom_range(80, 130);
         repeat (phase_steps) step_queue.push_back(random_step());
         settle();
      end

      $display("Run covered %0d step transfers and %0d advantage results over %0d settings,",
               board.steps_noted, board.results_checked, settings_used);
      $display("with saturation, episode ends, clamped factors and odd row shapes.");
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
rtl/cas_pkg.sv
rtl/cas_if.sv
rtl/cas_csr.sv
rtl/cas_mul_unit.sv
rtl/clipped_advantage_scan_core.sv
verif/advantage_scoreboard_pkg.sv
verif/clipped_advantage_scan_core_tb.sv
